// ----- rtl/core/cdq_pkg.sv -----
// ----------------------------------------------------------------------------
// cdq_pkg: shared types and constants for the circular deque
// Command codes, configuration register layout and default sizes.
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int DefMaxDepth  = 16;
  localparam int DefWordWidth = 32;

  // command field
  localparam int CmdW = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_BACK  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_PEEK       = 2'd3
  } cmd_e;

  // capacity register
  localparam int          CapW     = 5;
  localparam int          CapReset = 16;

endpackage

// ----- rtl/core/cdq_if.sv -----
// ----------------------------------------------------------------------------
// cdq_cmd_if / cdq_rsp_if: valid/ready channels of the circular deque
// Command beats carry a command code and a data word; response beats carry
// the outcome of one command and a snapshot of the deque ends.
// ----------------------------------------------------------------------------
interface cdq_cmd_if #(
  parameter int WordWidth = cdq_pkg::DefWordWidth
);
  import cdq_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [CmdW-1:0]             command;
  logic signed [WordWidth-1:0] data_value;

  modport source (output valid, command, data_value, input ready);
  modport sink   (input valid, command, data_value, output ready);
endinterface

interface cdq_rsp_if #(
  parameter int WordWidth = cdq_pkg::DefWordWidth
);
  logic                        valid;
  logic                        ready;
  logic signed [WordWidth-1:0] popped_value;
  logic                        pop_ok;
  logic                        push_refused;
  logic signed [WordWidth-1:0] front_value;
  logic signed [WordWidth-1:0] back_value;
  logic                        is_empty;
  logic                        is_full;

  modport source (output valid, popped_value, pop_ok, push_refused, front_value,
                  back_value, is_empty, is_full, input ready);
  modport sink   (input valid, popped_value, pop_ok, push_refused, front_value,
                  back_value, is_empty, is_full, output ready);
endinterface

// ----- rtl/core/cdq_store.sv -----
// ----------------------------------------------------------------------------
// cdq_store: word storage of the circular deque
// One write port and one registered read port; a read of the address being
// written in the same cycle returns the new word.
// ----------------------------------------------------------------------------
module cdq_store #(
  parameter int MaxDepth  = cdq_pkg::DefMaxDepth,
  parameter int WordWidth = cdq_pkg::DefWordWidth,
  parameter int AddrW     = $clog2(MaxDepth)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  logic [WordWidth-1:0] wdata_i,
  input  logic [AddrW-1:0]     raddr_i,
  output logic [WordWidth-1:0] rdata_o
);
  import cdq_pkg::*;

  logic [WordWidth-1:0] mem_q [MaxDepth];
  logic [WordWidth-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // write-first read
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/circular_deque.sv -----
// ----------------------------------------------------------------------------
// circular_deque: fixed-capacity double-ended queue of signed words
// Push front, push back, pop front and peek, one response per command.
// ----------------------------------------------------------------------------
// The deque takes one command beat per clock and returns its response beat
// in the next cycle from an output register; a new command is taken in the
// same cycle the pending response is taken, so throughput is one command per
// cycle while the response side keeps up. The front and back words are held
// in registers and the word behind the front is prefetched from the single
// read port of the storage, so a pop never waits on a memory read. Pushes to
// a full deque are dropped and flagged, a pop on an empty deque answers all
// ones. Writing the capacity register (0 acts as 1, values above MaxDepth act
// as MaxDepth) empties the deque; it must only be written while idle. There
// is no clearing pass after reset.
// ----------------------------------------------------------------------------
module circular_deque #(
  parameter int MaxDepth  = cdq_pkg::DefMaxDepth,
  parameter int WordWidth = cdq_pkg::DefWordWidth
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [cdq_pkg::CapW-1:0] cfg_wdata_i,
  cdq_cmd_if.sink                  cmd_i,
  cdq_rsp_if.source                rsp_o
);
  import cdq_pkg::*;

  localparam int AddrW     = $clog2(MaxDepth);
  localparam int CntW      = $clog2(MaxDepth + 1);
  localparam int CapRstEff = (CapReset > MaxDepth) ? MaxDepth : CapReset;

  localparam logic [WordWidth-1:0] AllOnes = '1;

  // state
  logic [CntW-1:0]      cap_q, cap_wr;
  logic [CntW-1:0]      occ_q, occ_d;
  logic [AddrW-1:0]     head_q, head_d, tail_q, tail_d;
  logic [WordWidth-1:0] front_q, front_d, back_q, back_d;

  // storage port
  logic                 mem_we;
  logic [AddrW-1:0]     mem_waddr, mem_raddr;
  logic [WordWidth-1:0] nxt_word;

  // helpers
  logic [AddrW-1:0]     cap_last, head_dec, head_inc, tail_inc;
  logic                 accept;

  // response
  logic                 out_valid_q;
  logic [WordWidth-1:0] popped_d, popped_q;
  logic                 pop_ok_d, pop_ok_q, refused_d, refused_q;
  logic [WordWidth-1:0] front_out_q, back_out_q;
  logic                 empty_q, full_q;

  assign cmd_i.ready = !out_valid_q || rsp_o.ready;
  assign accept      = cmd_i.valid && cmd_i.ready;

  // clamp the written capacity to 1..MaxDepth
  always_comb begin
    if (cfg_wdata_i == '0) begin
      cap_wr = CntW'(1);
    end else if (32'(cfg_wdata_i) > MaxDepth) begin
      cap_wr = CntW'(MaxDepth);
    end else begin
      cap_wr = CntW'(cfg_wdata_i);
    end
  end

  assign cap_last = AddrW'(cap_q - 1'b1);
  assign head_dec = (head_q == '0) ? cap_last : head_q - 1'b1;
  assign head_inc = (head_q == cap_last) ? '0 : head_q + 1'b1;
  assign tail_inc = (tail_q == cap_last) ? '0 : tail_q + 1'b1;

  always_comb begin
    occ_d     = occ_q;
    head_d    = head_q;
    tail_d    = tail_q;
    front_d   = front_q;
    back_d    = back_q;
    mem_we    = 1'b0;
    mem_waddr = head_q;
    popped_d  = AllOnes;
    pop_ok_d  = 1'b0;
    refused_d = 1'b0;
    if (accept) begin
      case (cmd_e'(cmd_i.command))
        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
          if (occ_q == cap_q) begin
            refused_d = 1'b1;
          end else if (occ_q == '0) begin
            tail_d  = head_q;
            mem_we  = 1'b1;
            front_d = cmd_i.data_value;
            back_d  = cmd_i.data_value;
            occ_d   = CntW'(1);
          end else if (cmd_e'(cmd_i.command) == CMD_PUSH_FRONT) begin
            head_d    = head_dec;
            mem_we    = 1'b1;
            mem_waddr = head_dec;
            front_d   = cmd_i.data_value;
            occ_d     = occ_q + 1'b1;
          end else begin
            tail_d    = tail_inc;
            mem_we    = 1'b1;
            mem_waddr = tail_inc;
            back_d    = cmd_i.data_value;
            occ_d     = occ_q + 1'b1;
          end
        end
        CMD_POP_FRONT: begin
          if (occ_q != '0) begin
            popped_d = front_q;
            pop_ok_d = 1'b1;
            occ_d    = occ_q - 1'b1;
            if (occ_q == CntW'(1)) begin
              tail_d = head_q;
            end else begin
              head_d  = head_inc;
              front_d = nxt_word;
            end
          end
        end
        default: begin
          // peek leaves the state alone
        end
      endcase
    end
  end

  // keep the word behind the front prefetched
  assign mem_raddr = (head_d == cap_last) ? '0 : head_d + 1'b1;

  cdq_store #(
    .MaxDepth (MaxDepth),
    .WordWidth(WordWidth),
    .AddrW    (AddrW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(cmd_i.data_value),
    .raddr_i(mem_raddr),
    .rdata_o(nxt_word)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= CntW'(CapRstEff);
      occ_q  <= '0;
      head_q <= '0;
      tail_q <= '0;
    end else if (cfg_we_i) begin
      cap_q  <= cap_wr;
      occ_q  <= '0;
      head_q <= '0;
      tail_q <= '0;
    end else begin
      occ_q  <= occ_d;
      head_q <= head_d;
      tail_q <= tail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    front_q <= front_d;
    back_q  <= back_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      popped_q    <= popped_d;
      pop_ok_q    <= pop_ok_d;
      refused_q   <= refused_d;
      front_out_q <= (occ_d == '0) ? AllOnes : front_d;
      back_out_q  <= (occ_d == '0) ? AllOnes : back_d;
      empty_q     <= (occ_d == '0);
      full_q      <= (occ_d == cap_q);
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.popped_value = popped_q;
  assign rsp_o.pop_ok       = pop_ok_q;
  assign rsp_o.push_refused = refused_q;
  assign rsp_o.front_value  = front_out_q;
  assign rsp_o.back_value   = back_out_q;
  assign rsp_o.is_empty     = empty_q;
  assign rsp_o.is_full      = full_q;

endmodule

// ----- rtl/core/cdq_checker.sv -----
// ----------------------------------------------------------------------------
// cdq_checker: port-level checks of the circular deque
// Watches the response channel and flags inconsistent beats.
// ----------------------------------------------------------------------------
module cdq_checker #(
  parameter int WordWidth = cdq_pkg::DefWordWidth
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input logic [WordWidth-1:0] popped_i,
  input logic                 pop_ok_i,
  input logic                 refused_i,
  input logic [WordWidth-1:0] front_i,
  input logic [WordWidth-1:0] back_i,
  input logic                 empty_i,
  input logic                 full_i
);
  import cdq_pkg::*;

  localparam logic [WordWidth-1:0] AllOnes = '1;

  // a stalled response beat stays up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("response beat dropped while stalled");

  // capacity is never zero, so empty and full exclude each other
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(empty_i && full_i))
    else $error("deque reported both empty and full");

  // one command cannot both pop and refuse a push
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(pop_ok_i && refused_i))
    else $error("pop and refused push in one beat");

  // no pop means the popped word reads all ones
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !pop_ok_i |-> popped_i == AllOnes)
    else $error("popped word without a pop");

  // an empty deque shows all ones at both ends
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && empty_i |-> (front_i == AllOnes) && (back_i == AllOnes))
    else $error("empty deque shows a live end word");

endmodule

bind circular_deque cdq_checker #(
  .WordWidth(WordWidth)
) u_cdq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(rsp_o.valid),
  .out_ready_i(rsp_o.ready),
  .popped_i   (rsp_o.popped_value),
  .pop_ok_i   (rsp_o.pop_ok),
  .refused_i  (rsp_o.push_refused),
  .front_i    (rsp_o.front_value),
  .back_i     (rsp_o.back_value),
  .empty_i    (rsp_o.is_empty),
  .full_i     (rsp_o.is_full)
);
